### rtl/dmad_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dmad_pkg: shared types and constants of the dual moving average block
// Transaction payloads, the stored sample pair, the register map and the
// window that a sample pair must lie inside.
// -----------------------------------------------------------------------------
package dmad_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int DEADBAND_W = 10;
   localparam int CSR_INDEX_W = 1;

   // Register map.
   localparam logic [CSR_INDEX_W-1:0] REG_HUMIDITY_DEADBAND    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPERATURE_DEADBAND = 1'd1;

   localparam logic [DEADBAND_W-1:0] HUMIDITY_DEADBAND_RESET    = 10'd10;
   localparam logic [DEADBAND_W-1:0] TEMPERATURE_DEADBAND_RESET = 10'd5;

   // Samples must lie strictly between these bounds (-40.0 and 125.0).
   localparam logic signed [SAMPLE_W-1:0] VALID_LOW  = -12'sd400;
   localparam logic signed [SAMPLE_W-1:0] VALID_HIGH = 12'sd1250;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] humidity_sample;
      logic signed [SAMPLE_W-1:0] temperature_sample;
      logic                       read_failed;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] humidity_report;
      logic signed [SAMPLE_W-1:0] temperature_report;
      logic                       report_changed;
      logic                       sample_rejected;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] humidity;
      logic signed [SAMPLE_W-1:0] temperature;
   } sample_pair_type;

endpackage

### rtl/dmad_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dmad_req_if / dmad_rsp_if: valid/ready channels of the block
// A transaction moves at a rising clock edge with valid and ready both high.
// -----------------------------------------------------------------------------
interface dmad_req_if;
   logic             valid;
   logic             ready;
   dmad_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dmad_rsp_if;
   logic             valid;
   logic             ready;
   dmad_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/dual_moving_average_deadband.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dual_moving_average_deadband: humidity and temperature moving averages
// Two SAMPLE_COUNT-deep moving averages with a shared deadband-gated report.
// -----------------------------------------------------------------------------
// The block takes one sample pair per clock cycle while the response side is
// ready and returns exactly one result transaction for each, in order. A pair
// lands in an input register; once the output register is free or being
// drained, the running sums, the two means and the deadband decision are
// worked out and the result is written to the output register. The loop that
// sets the rate, the running-sum update followed by the reciprocal multiply
// and the deadband compare, has no register inside it, so one transaction per
// cycle is sustained while that side is ready. When the response side stalls,
// one more request is still taken into the input register. The ring starts
// out as zeros after reset through per-entry valid bits, so no clearing pass
// is needed and the block is ready right away. Deadband registers are to be
// written through the csr port only while the block is idle; the block does
// not enforce it. Index 0 is the humidity and index 1 the temperature deadband.
// -----------------------------------------------------------------------------
module dual_moving_average_deadband #(
   parameter int SAMPLE_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   dmad_req_if.sink                            req_channel,
   dmad_rsp_if.source                          rsp_channel,
   input  logic                                csr_write,
   input  logic [dmad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dmad_pkg::DEADBAND_W-1:0]     csr_data
);
   import dmad_pkg::*;

   // A sum of SAMPLE_COUNT values in the valid window fits in this width.
   localparam int LOG_N = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 0;
   localparam int SUM_W = SAMPLE_W + LOG_N;

   // Deadband registers.
   logic [DEADBAND_W-1:0] humidity_deadband_ff;
   logic [DEADBAND_W-1:0] temperature_deadband_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         humidity_deadband_ff    <= HUMIDITY_DEADBAND_RESET;
         temperature_deadband_ff <= TEMPERATURE_DEADBAND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_HUMIDITY_DEADBAND: begin
               humidity_deadband_ff <= csr_data;
            end
            REG_TEMPERATURE_DEADBAND: begin
               temperature_deadband_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Input register and output register. The processing stage fires when it
   // holds a transaction and the output register is free or being drained.
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   logic    fire;

   assign advance           = !out_valid_ff || rsp_channel.ready;
   assign fire              = in_valid_ff && advance;
   assign req_channel.ready = !in_valid_ff || advance;
   assign rsp_channel.valid = out_valid_ff;
   assign rsp_channel.payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_channel.ready) begin
         in_valid_ff <= req_channel.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_channel.ready && req_channel.valid) begin
         in_data_ff <= req_channel.payload;
      end
   end

   // Sample window check. A failed read or any value on or outside the
   // window bounds rejects the whole pair.
   logic signed [SAMPLE_W-1:0] humidity;
   logic signed [SAMPLE_W-1:0] temperature;
   logic                       rejected;
   logic                       store;

   assign humidity    = in_data_ff.humidity_sample;
   assign temperature = in_data_ff.temperature_sample;
   assign rejected    = in_data_ff.read_failed
                        || !(humidity > VALID_LOW && humidity < VALID_HIGH)
                        || !(temperature > VALID_LOW && temperature < VALID_HIGH);
   assign store       = fire && !rejected;

   // Ring storage: gives the pair that the current write replaces.
   sample_pair_type write_pair;
   sample_pair_type old_pair;

   assign write_pair.humidity    = humidity;
   assign write_pair.temperature = temperature;

   dmad_ring #(
      .DEPTH(SAMPLE_COUNT)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .write_en  (store),
      .write_pair(write_pair),
      .old_pair  (old_pair)
   );

   // Running sums: add the new sample and drop the one it replaces.
   logic signed [SUM_W-1:0] humidity_sum_ff, humidity_sum_in;
   logic signed [SUM_W-1:0] temperature_sum_ff, temperature_sum_in;

   assign humidity_sum_in    = humidity_sum_ff + SUM_W'(humidity)
                               - SUM_W'(old_pair.humidity);
   assign temperature_sum_in = temperature_sum_ff + SUM_W'(temperature)
                               - SUM_W'(old_pair.temperature);

   logic signed [SAMPLE_W-1:0] humidity_mean;
   logic signed [SAMPLE_W-1:0] temperature_mean;

   dmad_mean #(
      .DEPTH(SAMPLE_COUNT),
      .SUM_W(SUM_W)
   ) u_humidity_mean (
      .sum (humidity_sum_in),
      .mean(humidity_mean)
   );

   dmad_mean #(
      .DEPTH(SAMPLE_COUNT),
      .SUM_W(SUM_W)
   ) u_temperature_mean (
      .sum (temperature_sum_in),
      .mean(temperature_mean)
   );

   // Deadband decision. Differences are taken one bit wider so that they
   // cannot wrap, and the magnitude is compared against the deadband.
   logic signed [SAMPLE_W-1:0] humidity_current_ff;
   logic signed [SAMPLE_W-1:0] temperature_current_ff;
   logic signed [SAMPLE_W:0]   humidity_diff;
   logic signed [SAMPLE_W:0]   temperature_diff;
   logic        [SAMPLE_W:0]   humidity_dist;
   logic        [SAMPLE_W:0]   temperature_dist;
   logic                       update;

   always_comb begin
      humidity_diff    = (SAMPLE_W + 1)'(humidity_mean)
                         - (SAMPLE_W + 1)'(humidity_current_ff);
      temperature_diff = (SAMPLE_W + 1)'(temperature_mean)
                         - (SAMPLE_W + 1)'(temperature_current_ff);
      humidity_dist    = humidity_diff[SAMPLE_W] ? -humidity_diff : humidity_diff;
      temperature_dist = temperature_diff[SAMPLE_W] ? -temperature_diff
                                                    : temperature_diff;
      update = store
               && ((humidity_dist > (SAMPLE_W + 1)'(humidity_deadband_ff))
                   || (temperature_dist > (SAMPLE_W + 1)'(temperature_deadband_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         humidity_sum_ff        <= '0;
         temperature_sum_ff     <= '0;
         humidity_current_ff    <= '0;
         temperature_current_ff <= '0;
      end else begin
         if (store) begin
            humidity_sum_ff    <= humidity_sum_in;
            temperature_sum_ff <= temperature_sum_in;
         end
         if (update) begin
            humidity_current_ff    <= humidity_mean;
            temperature_current_ff <= temperature_mean;
         end
      end
   end

   // Result register. A result always carries the reports as they stand
   // after its own transaction.
   rsp_type out_data_in;

   always_comb begin
      out_data_in.humidity_report    = update ? humidity_mean : humidity_current_ff;
      out_data_in.temperature_report = update ? temperature_mean
                                              : temperature_current_ff;
      out_data_in.report_changed     = update;
      out_data_in.sample_rejected    = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

### rtl/dmad_ring.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dmad_ring: sample pair ring with write pointer and prefetched oldest entry
// Holds the last DEPTH accepted pairs. The entry at the write pointer (the one
// about to be replaced) is always available on old_pair; entries never
// written since reset read as zero.
// -----------------------------------------------------------------------------
module dmad_ring #(
   parameter int DEPTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      write_en,
   input  dmad_pkg::sample_pair_type write_pair,
   output dmad_pkg::sample_pair_type old_pair
);
   import dmad_pkg::*;

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

   sample_pair_type mem [DEPTH];

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic              old_valid_ff;
   logic              bypass_ff;
   sample_pair_type   mem_rd_ff;
   sample_pair_type   bypass_pair_ff;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (write_en) begin
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         valid_in[slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         valid_ff     <= '0;
         old_valid_ff <= 1'b0;
         bypass_ff    <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         old_valid_ff <= valid_ff[slot_in];
         // Only a one-entry ring reads back the slot it is writing.
         bypass_ff    <= write_en && (slot_in == slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[slot_ff] <= write_pair;
      end
      mem_rd_ff      <= mem[slot_in];
      bypass_pair_ff <= write_pair;
   end

   always_comb begin
      if (bypass_ff) begin
         old_pair = bypass_pair_ff;
      end else if (old_valid_ff) begin
         old_pair = mem_rd_ff;
      end else begin
         old_pair = '0;
      end
   end

endmodule

### rtl/dmad_mean.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dmad_mean: running sum divided by the ring depth, truncated toward zero
// The magnitude is multiplied by a rounded-up reciprocal that is exact for
// every sum the ring can hold, then the sign is put back.
// -----------------------------------------------------------------------------
module dmad_mean #(
   parameter int DEPTH = 8,
   parameter int SUM_W = 15
) (
   input  logic signed [SUM_W-1:0]             sum,
   output logic signed [dmad_pkg::SAMPLE_W-1:0] mean
);
   import dmad_pkg::*;

   localparam int MAG_W   = SUM_W - 1;
   localparam int LOG_D   = (DEPTH > 1) ? $clog2(DEPTH) : 0;
   localparam int SHIFT   = MAG_W + LOG_D + 1;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

   logic              negative;
   logic [SUM_W-1:0]  sum_abs;
   logic [MAG_W-1:0]  magnitude;
   logic [PROD_W-1:0] product;
   logic [SAMPLE_W-1:0] quotient;

   always_comb begin
      negative  = sum[SUM_W-1];
      sum_abs   = negative ? SUM_W'(-sum) : SUM_W'(sum);
      magnitude = sum_abs[MAG_W-1:0];
      product   = PROD_W'(magnitude) * PROD_W'(RECIP);
      quotient  = product[SHIFT +: SAMPLE_W];
      mean      = negative ? -$signed(quotient) : $signed(quotient);
   end

endmodule

### rtl/dmad_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dmad_checker: port-level checks of the dual moving average block
// Tracks delivered reports, deadbands and outstanding transactions.
// -----------------------------------------------------------------------------
module dmad_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input dmad_pkg::rsp_type                rsp_payload,
   input logic                             csr_write,
   input logic [dmad_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [dmad_pkg::DEADBAND_W-1:0]  csr_data
);
   import dmad_pkg::*;

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   logic [DEADBAND_W-1:0]      hdb_ff;
   logic [DEADBAND_W-1:0]      tdb_ff;
   logic signed [SAMPLE_W-1:0] last_h_ff;
   logic signed [SAMPLE_W-1:0] last_t_ff;
   logic [2:0]                 pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdb_ff     <= HUMIDITY_DEADBAND_RESET;
         tdb_ff     <= TEMPERATURE_DEADBAND_RESET;
         last_h_ff  <= '0;
         last_t_ff  <= '0;
         pending_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_HUMIDITY_DEADBAND: begin
                  hdb_ff <= csr_data;
               end
               REG_TEMPERATURE_DEADBAND: begin
                  tdb_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_fire) begin
            last_h_ff <= rsp_payload.humidity_report;
            last_t_ff <= rsp_payload.temperature_report;
         end
         pending_ff <= pending_ff + 3'(req_fire) - 3'(rsp_fire);
      end
   end

   logic signed [SAMPLE_W:0] h_diff;
   logic signed [SAMPLE_W:0] t_diff;
   logic        [SAMPLE_W:0] h_dist;
   logic        [SAMPLE_W:0] t_dist;

   always_comb begin
      h_diff = (SAMPLE_W + 1)'(rsp_payload.humidity_report) - (SAMPLE_W + 1)'(last_h_ff);
      t_diff = (SAMPLE_W + 1)'(rsp_payload.temperature_report)
               - (SAMPLE_W + 1)'(last_t_ff);
      h_dist = h_diff[SAMPLE_W] ? -h_diff : h_diff;
      t_dist = t_diff[SAMPLE_W] ? -t_diff : t_diff;
   end

   // Without a change, the reports are the ones delivered last.
   held_reports: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_payload.report_changed
      |-> rsp_payload.humidity_report == last_h_ff
          && rsp_payload.temperature_report == last_t_ff)
      else $error("reports moved without report_changed");

   // A change is only made when a deadband is exceeded.
   change_exceeds_deadband: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_payload.report_changed
      |-> h_dist > (SAMPLE_W + 1)'(hdb_ff) || t_dist > (SAMPLE_W + 1)'(tdb_ff))
      else $error("report changed within both deadbands");

   // Every result answers an earlier request, and at most two are in flight.
   no_result_without_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result offered with no request outstanding");

   bounded_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more than two transactions in flight");

endmodule

bind dual_moving_average_deadband dmad_checker u_dmad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_channel.valid),
   .req_ready  (req_channel.ready),
   .rsp_valid  (rsp_channel.valid),
   .rsp_ready  (rsp_channel.ready),
   .rsp_payload(rsp_channel.payload),
   .csr_write  (csr_write),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);
